// ----- rtl/wlru_pkg.sv -----
// Shared widths, codes, types and reset values of the weighted LRU cache.
`default_nettype none
package wlru_pkg;

  localparam int unsigned DEFAULT_CAPACITY = 32;

  localparam int unsigned KEY_W       = 32;
  localparam int unsigned HANDLE_W    = 16;
  localparam int unsigned WEIGHT_W    = 20;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned TOTAL_OUT_W = 25;
  localparam int unsigned COUNT_OUT_W = 6;
  localparam int unsigned IN_DATA_W   = 72;
  localparam int unsigned OUT_DATA_W  = 56;

  localparam logic [TOTAL_OUT_W-1:0] BUDGET_RESET = 25'd50000;
  localparam logic [TOTAL_OUT_W-1:0] TOTAL_MAX    = 25'h1FFFFFF;

  localparam logic [OP_W-1:0] OP_GET  = 2'd0;
  localparam logic [OP_W-1:0] OP_PUT  = 2'd1;
  localparam logic [OP_W-1:0] OP_DROP = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic [WEIGHT_W-1:0] weight;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_MOVE,
    ST_FRONT,
    ST_EV_CHK,
    ST_EV_RD,
    ST_EV_WT,
    ST_RESP
  } state_e;

endpackage
`default_nettype wire

// ----- rtl/weighted_lru_cache.sv -----
// Weighted LRU cache: sequencer, entry memory in recency order and running weight total.
// Steps per item: search; on a put that misses a full cache, eviction of the back entry;
// shift of the order; front write (not on a drop); on a put, a budget check with an eviction
// while over budget; then the result register. One memory read and one write a cycle.
// One item at a time: a new item is taken only once the last result is registered.
// Reset: entry count and total cleared, row budget 50000; entry memory is not cleared.
`default_nettype none
module weighted_lru_cache #(
  parameter int unsigned CAPACITY = wlru_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // tdata: key_id[31:0], data_handle[47:32], row_weight[67:48], zero fill
  input  wire logic [wlru_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // tuser: operation[1:0]
  input  wire logic [wlru_pkg::OP_W-1:0]            s_axis_tuser,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // tdata: hit[0], handle_out[16:1], evicted_count[22:17], entries_in_use[28:23],
  //        total_rows[53:29], zero fill
  output logic [wlru_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  input  wire logic [wlru_pkg::TOTAL_OUT_W-1:0]     cfg_data_i,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o
);

  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned TOT_W   = (wlru_pkg::WEIGHT_W + CNT_W > wlru_pkg::TOTAL_OUT_W) ?
                                    wlru_pkg::WEIGHT_W + CNT_W : wlru_pkg::TOTAL_OUT_W;
  localparam int unsigned CNT_X_W = (CNT_W > wlru_pkg::COUNT_OUT_W) ?
                                    CNT_W : wlru_pkg::COUNT_OUT_W;

  wlru_pkg::state_e state_q, state_d;

  logic [wlru_pkg::OP_W-1:0]        op_q, op_d;
  logic [wlru_pkg::KEY_W-1:0]       key_q, key_d;
  logic [wlru_pkg::HANDLE_W-1:0]    hnd_q, hnd_d;
  logic [wlru_pkg::WEIGHT_W-1:0]    wgt_q, wgt_d;
  logic [CNT_W-1:0]                 cnt_q, cnt_d;
  logic [TOT_W-1:0]                 tot_q, tot_d;
  logic [wlru_pkg::TOTAL_OUT_W-1:0] budget_q;
  logic [CNT_W-1:0]                 rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]                 cmp_ptr_q, cmp_ptr_d;
  logic                             rvalid_q, rvalid_d;
  logic                             hit_q, hit_d;
  logic [wlru_pkg::HANDLE_W-1:0]    hout_q, hout_d;
  logic [CNT_W-1:0]                 evc_q, evc_d;
  logic                             ins_q, ins_d;
  logic [CNT_W-1:0]                 src_q, src_d;
  logic [CNT_W-1:0]                 rem_q, rem_d;
  logic                             down_q, down_d;
  logic                             wpend_q, wpend_d;
  logic [CNT_W-1:0]                 wsrc_q, wsrc_d;
  wlru_pkg::entry_t                 front_q, front_d;
  logic                             ovalid_q, ovalid_d;
  logic [wlru_pkg::OUT_DATA_W-1:0]  odata_q, odata_d;

  wlru_pkg::entry_t entry_mem_q [CAPACITY];
  wlru_pkg::entry_t rdata_q;
  logic             mem_re, mem_we;
  logic [POS_W-1:0] mem_raddr, mem_waddr;
  wlru_pkg::entry_t mem_wdata;

  logic                             s_accept;
  logic                             key_match, found, miss;
  logic                             move_done, over_budget, out_free;
  logic [CNT_W-1:0]                 mv_dst;
  logic [CNT_W-1:0]                 cnt_m1;
  logic [TOT_W-1:0]                 rd_wgt;
  logic [CNT_X_W-1:0]               cnt_x, evc_x;
  logic [wlru_pkg::TOTAL_OUT_W-1:0] total_sat;

  assign s_accept    = s_axis_tvalid && s_axis_tready;
  assign key_match   = rvalid_q && (rdata_q.key == key_q);
  assign found       = (state_q == wlru_pkg::ST_SRCH) && key_match;
  assign cnt_m1      = cnt_q - CNT_W'(1);
  assign miss        = (state_q == wlru_pkg::ST_SRCH) && !key_match &&
                       ((cnt_q == '0) || (rvalid_q && (cmp_ptr_q == cnt_m1)));
  assign move_done   = (rem_q == '0) && !wpend_q;
  assign over_budget = (cnt_q > CNT_W'(1)) && (tot_q > TOT_W'(budget_q));
  assign out_free    = !ovalid_q || m_axis_tready;
  assign mv_dst      = down_q ? wsrc_q + CNT_W'(1) : wsrc_q - CNT_W'(1);
  assign rd_wgt      = TOT_W'(rdata_q.weight);
  assign cnt_x       = CNT_X_W'(cnt_q);
  assign evc_x       = CNT_X_W'(evc_q);
  assign total_sat   = (tot_q > TOT_W'(wlru_pkg::TOTAL_MAX)) ?
                       wlru_pkg::TOTAL_MAX : tot_q[wlru_pkg::TOTAL_OUT_W-1:0];

  assign s_axis_tready = (state_q == wlru_pkg::ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      wlru_pkg::ST_IDLE: begin
        if (s_accept) begin
          if (s_axis_tuser == wlru_pkg::OP_GET || s_axis_tuser == wlru_pkg::OP_PUT ||
              s_axis_tuser == wlru_pkg::OP_DROP) begin
            state_d = wlru_pkg::ST_SRCH;
          end else begin
            state_d = wlru_pkg::ST_RESP;
          end
        end
      end
      wlru_pkg::ST_SRCH: begin
        if (found) begin
          state_d = wlru_pkg::ST_MOVE;
        end else if (miss) begin
          if (op_q == wlru_pkg::OP_PUT) begin
            state_d = (cnt_q >= CNT_W'(CAPACITY)) ? wlru_pkg::ST_EV_RD : wlru_pkg::ST_MOVE;
          end else begin
            state_d = wlru_pkg::ST_RESP;
          end
        end
      end
      wlru_pkg::ST_MOVE: begin
        if (move_done) begin
          state_d = (op_q == wlru_pkg::OP_DROP) ? wlru_pkg::ST_RESP : wlru_pkg::ST_FRONT;
        end
      end
      wlru_pkg::ST_FRONT: begin
        state_d = (op_q == wlru_pkg::OP_PUT) ? wlru_pkg::ST_EV_CHK : wlru_pkg::ST_RESP;
      end
      wlru_pkg::ST_EV_CHK: begin
        state_d = over_budget ? wlru_pkg::ST_EV_RD : wlru_pkg::ST_RESP;
      end
      wlru_pkg::ST_EV_RD: begin
        state_d = wlru_pkg::ST_EV_WT;
      end
      wlru_pkg::ST_EV_WT: begin
        state_d = ins_q ? wlru_pkg::ST_MOVE : wlru_pkg::ST_EV_CHK;
      end
      wlru_pkg::ST_RESP: begin
        if (out_free) begin
          state_d = wlru_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wlru_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    op_d      = op_q;
    key_d     = key_q;
    hnd_d     = hnd_q;
    wgt_d     = wgt_q;
    cnt_d     = cnt_q;
    tot_d     = tot_q;
    rd_ptr_d  = rd_ptr_q;
    cmp_ptr_d = cmp_ptr_q;
    rvalid_d  = 1'b0;
    hit_d     = hit_q;
    hout_d    = hout_q;
    evc_d     = evc_q;
    ins_d     = ins_q;
    src_d     = src_q;
    rem_d     = rem_q;
    down_d    = down_q;
    wpend_d   = 1'b0;
    wsrc_d    = wsrc_q;
    front_d   = front_q;
    ovalid_d  = ovalid_q && !m_axis_tready;
    odata_d   = odata_q;
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = front_q;
    case (state_q)
      wlru_pkg::ST_IDLE: begin
        if (s_accept) begin
          op_d     = s_axis_tuser;
          key_d    = s_axis_tdata[31:0];
          hnd_d    = s_axis_tdata[47:32];
          wgt_d    = s_axis_tdata[67:48];
          hit_d    = 1'b0;
          hout_d   = '0;
          evc_d    = '0;
          ins_d    = 1'b0;
          rd_ptr_d = '0;
          rem_d    = '0;
        end
      end
      wlru_pkg::ST_SRCH: begin
        if (rd_ptr_q < cnt_q) begin
          mem_re    = 1'b1;
          mem_raddr = rd_ptr_q[POS_W-1:0];
          rd_ptr_d  = rd_ptr_q + CNT_W'(1);
          rvalid_d  = 1'b1;
          cmp_ptr_d = rd_ptr_q;
        end
        if (found) begin
          hit_d = 1'b1;
          case (op_q)
            wlru_pkg::OP_GET: begin
              hout_d  = rdata_q.handle;
              front_d = rdata_q;
              rem_d   = cmp_ptr_q;
              src_d   = cmp_ptr_q - CNT_W'(1);
              down_d  = 1'b1;
            end
            wlru_pkg::OP_PUT: begin
              tot_d   = tot_q - rd_wgt;
              front_d = '{key: key_q, handle: hnd_q, weight: wgt_q};
              rem_d   = cmp_ptr_q;
              src_d   = cmp_ptr_q - CNT_W'(1);
              down_d  = 1'b1;
            end
            default: begin
              tot_d  = tot_q - rd_wgt;
              rem_d  = cnt_m1 - cmp_ptr_q;
              src_d  = cmp_ptr_q + CNT_W'(1);
              down_d = 1'b0;
              cnt_d  = cnt_m1;
            end
          endcase
        end else if (miss && op_q == wlru_pkg::OP_PUT) begin
          front_d = '{key: key_q, handle: hnd_q, weight: wgt_q};
          if (cnt_q >= CNT_W'(CAPACITY)) begin
            ins_d = 1'b1;
          end else begin
            rem_d  = cnt_q;
            src_d  = cnt_m1;
            down_d = 1'b1;
            cnt_d  = cnt_q + CNT_W'(1);
          end
        end
      end
      wlru_pkg::ST_MOVE: begin
        if (wpend_q) begin
          mem_we    = 1'b1;
          mem_waddr = mv_dst[POS_W-1:0];
          mem_wdata = rdata_q;
        end
        if (rem_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = src_q[POS_W-1:0];
          src_d     = down_q ? src_q - CNT_W'(1) : src_q + CNT_W'(1);
          rem_d     = rem_q - CNT_W'(1);
          wpend_d   = 1'b1;
          wsrc_d    = src_q;
        end
      end
      wlru_pkg::ST_FRONT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = front_q;
        if (op_q == wlru_pkg::OP_PUT) begin
          tot_d = tot_q + TOT_W'(wgt_q);
        end
      end
      wlru_pkg::ST_EV_RD: begin
        mem_re    = 1'b1;
        mem_raddr = cnt_m1[POS_W-1:0];
      end
      wlru_pkg::ST_EV_WT: begin
        tot_d = tot_q - rd_wgt;
        evc_d = evc_q + CNT_W'(1);
        if (ins_q) begin
          ins_d  = 1'b0;
          rem_d  = cnt_m1;
          src_d  = cnt_q - CNT_W'(2);
          down_d = 1'b1;
        end else begin
          cnt_d = cnt_m1;
        end
      end
      wlru_pkg::ST_RESP: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          odata_d  = {2'b00, total_sat, cnt_x[wlru_pkg::COUNT_OUT_W-1:0],
                      evc_x[wlru_pkg::COUNT_OUT_W-1:0], hout_q, hit_q};
        end
      end
      default: begin
        ovalid_d = ovalid_q && !m_axis_tready;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= entry_mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= wlru_pkg::ST_IDLE;
      cnt_q    <= '0;
      tot_q    <= '0;
      budget_q <= wlru_pkg::BUDGET_RESET;
      rvalid_q <= 1'b0;
      wpend_q  <= 1'b0;
      rem_q    <= '0;
      ins_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      tot_q    <= tot_d;
      rvalid_q <= rvalid_d;
      wpend_q  <= wpend_d;
      rem_q    <= rem_d;
      ins_q    <= ins_d;
      ovalid_q <= ovalid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        budget_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    hnd_q     <= hnd_d;
    wgt_q     <= wgt_d;
    rd_ptr_q  <= rd_ptr_d;
    cmp_ptr_q <= cmp_ptr_d;
    hit_q     <= hit_d;
    hout_q    <= hout_d;
    evc_q     <= evc_d;
    src_q     <= src_d;
    down_q    <= down_d;
    wsrc_q    <= wsrc_d;
    front_q   <= front_d;
    odata_q   <= odata_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q == wlru_pkg::ST_RESP))
    else $error("result raised outside the response step");

  a_evict_drops_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wlru_pkg::ST_EV_WT && !ins_q) |=> cnt_q == $past(cnt_m1))
    else $error("eviction did not remove exactly one entry");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (CNT_W'(mem_waddr) < cnt_q))
    else $error("entry write outside the occupied range");

endmodule
`default_nettype wire
